// File: hw/rtl/ipdt_pkg.sv
// ----------------------------------------------------------------------------
// ipdt_pkg: shared types and constants
// Register indexes, opcodes, field widths and reset values of the IR
// pulse-distance transmitter.
// ----------------------------------------------------------------------------
package ipdt_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int DATA_W    = 4;
    localparam int BURST_W   = 8;
    localparam int SPACE_W   = 8;
    localparam int TRAILER_W = 10;
    localparam int COUNT_W   = 10;
    localparam int BIDX_W    = 3;
    localparam int REG_IDX_W = 2;
    localparam int WDATA_W   = 10;

    localparam logic [BURST_W-1:0]   BURST_RESET   = 8'd20;
    localparam logic [SPACE_W-1:0]   SPACE_RESET   = 8'd20;
    localparam logic [TRAILER_W-1:0] TRAILER_RESET = 10'd200;

    // bit index: start bit, four data bits, then trailer
    localparam logic [BIDX_W-1:0] BIT_START   = 3'd0;
    localparam logic [BIDX_W-1:0] BIT_LAST    = 3'd4;
    localparam logic [BIDX_W-1:0] BIT_TRAILER = 3'd5;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BURST   = 2'd0,
        REG_SPACE   = 2'd1,
        REG_TRAILER = 2'd2
    } ipdt_reg_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } ipdt_op_t;

    typedef struct packed {
        logic [BURST_W-1:0]   burst_cycles;
        logic [SPACE_W-1:0]   space_cycles;
        logic [TRAILER_W-1:0] trailer_cycles;
    } ipdt_cfg_t;

    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic frame_done;
    } ipdt_res_t;

endpackage

// File: hw/rtl/ipdt_if.sv
// ----------------------------------------------------------------------------
// ipdt_if: stream channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface ipdt_in_if
    import ipdt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                op;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, op, sample, input ready);
    modport sink   (input valid, op, sample, output ready);
endinterface

interface ipdt_out_if;
    logic valid;
    logic ready;
    logic led_on;
    logic busy_res;
    logic frame_done;

    modport source (output valid, led_on, busy_res, frame_done, input ready);
    modport sink   (input valid, led_on, busy_res, frame_done, output ready);
endinterface

// File: hw/rtl/ipdt_core.sv
// ----------------------------------------------------------------------------
// ipdt_core: frame sequencer
// Holds the frame state and works out the LED level, busy and done flags
// of one beat; the state advances on every accepted beat.
// ----------------------------------------------------------------------------
module ipdt_core
    import ipdt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                op,
    input  logic [SAMPLE_W-1:0] sample,
    input  ipdt_cfg_t           cfg,
    output ipdt_res_t           res
);

    logic               sending_reg,     sending_next;
    logic [DATA_W-1:0]  payload_reg,     payload_next;
    logic [BIDX_W-1:0]  bit_index_reg,   bit_index_next;
    logic               in_space_reg,    in_space_next;
    logic [COUNT_W-1:0] cycle_count_reg, cycle_count_next;
    logic               half_phase_reg,  half_phase_next;

    logic               trailer;
    logic               data_bit;
    logic [BIDX_W-1:0]  sel;
    logic [COUNT_W-1:0] seg_len;
    logic [COUNT_W-1:0] len;
    logic               burst;
    logic               seg_end;

    always_comb
    begin
        trailer = (bit_index_reg >= BIT_TRAILER);
        sel     = BIT_LAST - bit_index_reg;
        data_bit = 1'b1;
        if (!trailer && bit_index_reg != BIT_START)
        begin
            data_bit = payload_reg[sel[1:0]];
        end

        if (trailer)
        begin
            seg_len = cfg.trailer_cycles;
        end
        else if (!data_bit)
        begin
            seg_len = {1'b0, cfg.space_cycles, 1'b0};
        end
        else if (!in_space_reg)
        begin
            seg_len = {2'b00, cfg.burst_cycles};
        end
        else
        begin
            seg_len = {2'b00, cfg.space_cycles};
        end
        len = (seg_len == '0) ? COUNT_W'(1) : seg_len;

        burst   = !trailer && data_bit && !in_space_reg;
        seg_end = ({1'b0, cycle_count_reg} + (COUNT_W+1)'(1)) >= {1'b0, len};
    end

    always_comb
    begin
        sending_next     = sending_reg;
        payload_next     = payload_reg;
        bit_index_next   = bit_index_reg;
        in_space_next    = in_space_reg;
        cycle_count_next = cycle_count_reg;
        half_phase_next  = half_phase_reg;
        res.led_on       = 1'b0;
        res.frame_done   = 1'b0;

        if (op == OP_LOAD)
        begin
            if (!sending_reg)
            begin
                payload_next     = sample[SAMPLE_W-1 -: DATA_W];
                bit_index_next   = BIT_START;
                in_space_next    = 1'b0;
                cycle_count_next = '0;
                half_phase_next  = 1'b0;
                sending_next     = 1'b1;
            end
        end
        else if (sending_reg)
        begin
            res.led_on = burst && !half_phase_reg;
            if (!half_phase_reg)
            begin
                half_phase_next = 1'b1;
            end
            else
            begin
                half_phase_next = 1'b0;
                if (seg_end)
                begin
                    cycle_count_next = '0;
                    priority if (burst)
                    begin
                        in_space_next = 1'b1;
                    end
                    else if (trailer)
                    begin
                        sending_next   = 1'b0;
                        res.frame_done = 1'b1;
                        bit_index_next = BIT_START;
                        in_space_next  = 1'b0;
                    end
                    else
                    begin
                        bit_index_next = bit_index_reg + BIDX_W'(1);
                        in_space_next  = 1'b0;
                    end
                end
                else
                begin
                    cycle_count_next = cycle_count_reg + COUNT_W'(1);
                end
            end
        end
        res.busy_res = sending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg     <= 1'b0;
            payload_reg     <= '0;
            bit_index_reg   <= BIT_START;
            in_space_reg    <= 1'b0;
            cycle_count_reg <= '0;
            half_phase_reg  <= 1'b0;
        end
        else if (step)
        begin
            sending_reg     <= sending_next;
            payload_reg     <= payload_next;
            bit_index_reg   <= bit_index_next;
            in_space_reg    <= in_space_next;
            cycle_count_reg <= cycle_count_next;
            half_phase_reg  <= half_phase_next;
        end
    end

    // frame state never runs past the trailer
    a_bidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= BIT_TRAILER)
        else $error("bit index past trailer");

    // done ends the frame
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.frame_done |=> !sending_reg)
        else $error("frame still busy after done");

    // LED only lights inside a frame, never in the trailer
    a_led_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res.led_on |-> sending_reg && !trailer && res.busy_res)
        else $error("LED on outside a burst");

    // second half of a carrier cycle always ends with phase back at zero
    a_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step && sending_reg && op == OP_TICK && half_phase_reg |=> !half_phase_reg)
        else $error("half phase did not toggle back");

endmodule

// File: hw/rtl/ir_pulse_distance_transmitter.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter: IR pulse-distance frame transmitter
// Load beats start a frame from the top bits of a sample when idle; tick beats step
// the carrier half-periods and return the LED level for each.
// ----------------------------------------------------------------------------
// Each accepted command beat gives its result beat in the next cycle.
// Throughput: one beat per cycle while results are taken; the result register is the only stage.
// Reset: frame idle, registers at 20 / 20 / 200 carrier cycles.
// The result register frees as its beat is taken, so commands keep flowing.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter
    import ipdt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ipdt_in_if.sink              cmd,
    ipdt_out_if.source           res,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [WDATA_W-1:0]   wr_data
);

    ipdt_cfg_t cfg_reg;
    ipdt_res_t beat_res;
    ipdt_res_t res_data_reg;
    logic      res_valid_reg;
    logic      step;

    assign cmd.ready = !res_valid_reg || res.ready;
    assign step      = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.burst_cycles   <= BURST_RESET;
            cfg_reg.space_cycles   <= SPACE_RESET;
            cfg_reg.trailer_cycles <= TRAILER_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_BURST:   cfg_reg.burst_cycles   <= wr_data[BURST_W-1:0];
                REG_SPACE:   cfg_reg.space_cycles   <= wr_data[SPACE_W-1:0];
                REG_TRAILER: cfg_reg.trailer_cycles <= wr_data[TRAILER_W-1:0];
                default:     ;
            endcase
        end
    end

    ipdt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .op     (cmd.op),
        .sample (cmd.sample),
        .cfg    (cfg_reg),
        .res    (beat_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_data_reg <= beat_res;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.led_on     = res_data_reg.led_on;
    assign res.busy_res   = res_data_reg.busy_res;
    assign res.frame_done = res_data_reg.frame_done;

    // every accepted command yields a pending result beat
    a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> res_valid_reg)
        else $error("result lost after accepted command");

    // a stalled result beat is not overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |-> !step)
        else $error("command accepted over a stalled result");

    // done and busy never show together
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_data_reg.frame_done |-> !res_data_reg.busy_res)
        else $error("done with busy set");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: IR pulse-distance transmitter testbench
// Drives load and tick beats through the command channel and tracks frame
// state in a scoreboard, so every result beat is checked for LED level,
// busy and frame-done. Register settings go from zero-length segments up to
// the largest values, including changes made while a frame is running.
// Both channels stall at random, except in one calm phase.
// ----------------------------------------------------------------------------
module tb_top;
    import ipdt_pkg::*;

    localparam int STALL_PCT   = 19;
    localparam int WATCH_LIMIT = 5000;

    class ipdt_ledger;
        logic [BURST_W-1:0]   burst_len;
        logic [SPACE_W-1:0]   space_len;
        logic [TRAILER_W-1:0] trailer_len;
        bit                   sending;
        logic [DATA_W-1:0]    payload;
        logic [BIDX_W-1:0]    bit_idx;
        bit                   in_space;
        logic [COUNT_W-1:0]   cyc;
        bit                   half;
        ipdt_res_t            pending[$];
        int                   fails;
        int                   n_cmds;
        int                   n_checked;
        int                   n_frames;
        int                   n_ignored;

        function new();
            burst_len   = BURST_RESET;
            space_len   = SPACE_RESET;
            trailer_len = TRAILER_RESET;
            sending     = 1'b0;
            payload     = '0;
            bit_idx     = BIT_START;
            in_space    = 1'b0;
            cyc         = '0;
            half        = 1'b0;
        endfunction

        function void set_reg(ipdt_reg_t idx, logic [WDATA_W-1:0] data);
            case (idx)
                REG_BURST:   burst_len   = data[BURST_W-1:0];
                REG_SPACE:   space_len   = data[SPACE_W-1:0];
                REG_TRAILER: trailer_len = data[TRAILER_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the frame by one command beat and queue the result it gives
        function void note_cmd(ipdt_op_t op, logic [SAMPLE_W-1:0] sample);
            ipdt_res_t r;
            bit        tail;
            bit        cur;
            bit        burst;
            int        seg;
            r = '0;
            n_cmds++;
            if (op == OP_LOAD)
            begin
                if (sending)
                    n_ignored++;
                else
                begin
                    payload  = sample[SAMPLE_W-1 -: DATA_W];
                    bit_idx  = BIT_START;
                    in_space = 1'b0;
                    cyc      = '0;
                    half     = 1'b0;
                    sending  = 1'b1;
                end
            end
            else if (sending)
            begin
                tail = (bit_idx >= BIT_TRAILER);
                cur  = 1'b1;
                if (!tail && bit_idx != BIT_START)
                    cur = payload[DATA_W - int'(bit_idx)];
                if (tail)
                    seg = trailer_len;
                else if (!cur)
                    seg = 2 * int'(space_len);
                else if (!in_space)
                    seg = burst_len;
                else
                    seg = space_len;
                if (seg == 0)
                    seg = 1;
                burst    = !tail && cur && !in_space;
                r.led_on = burst && !half;
                if (!half)
                    half = 1'b1;
                else
                begin
                    half = 1'b0;
                    if (int'(cyc) + 1 >= seg)
                    begin
                        cyc = '0;
                        if (burst)
                            in_space = 1'b1;
                        else if (tail)
                        begin
                            sending      = 1'b0;
                            r.frame_done = 1'b1;
                            bit_idx      = BIT_START;
                            in_space     = 1'b0;
                            n_frames++;
                        end
                        else
                        begin
                            bit_idx  = bit_idx + 1'b1;
                            in_space = 1'b0;
                        end
                    end
                    else
                        cyc = cyc + 1'b1;
                end
            end
            r.busy_res = sending;
            pending.push_back(r);
        endfunction

        function void check_res(logic led, logic busy, logic done);
            ipdt_res_t want;
            if (pending.size() == 0)
            begin
                $error("result beat with no command outstanding");
                fails++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (led !== want.led_on)
            begin
                $error("led_on: expected %0b, got %0b", want.led_on, led);
                fails++;
            end
            if (busy !== want.busy_res)
            begin
                $error("busy_res: expected %0b, got %0b", want.busy_res, busy);
                fails++;
            end
            if (done !== want.frame_done)
            begin
                $error("frame_done: expected %0b, got %0b", want.frame_done, done);
                fails++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [WDATA_W-1:0]   wr_data;
    bit                   calm;
    int                   watch;
    ipdt_ledger           ledger = new();

    ipdt_in_if  cmd ();
    ipdt_out_if res ();

    ir_pulse_distance_transmitter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .res      (res),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (res.valid && res.ready)
                ledger.check_res(res.led_on, res.busy_res, res.frame_done);
            res.ready <= calm || ($urandom_range(99) >= STALL_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            watch <= 0;
        else if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
            watch <= 0;
        else if (watch >= WATCH_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            watch <= watch + 1;
    end

    task automatic send_beat(input ipdt_op_t op, input logic [SAMPLE_W-1:0] sample);
        if (!calm)
            while ($urandom_range(99) < STALL_PCT)
            begin
                cmd.valid <= 1'b0;
                @(posedge clk);
            end
        cmd.valid  <= 1'b1;
        cmd.op     <= op;
        cmd.sample <= sample;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        ledger.note_cmd(op, sample);
    endtask

    task automatic wait_drained();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_regs(input logic [BURST_W-1:0] b, input logic [SPACE_W-1:0] s,
                             input logic [TRAILER_W-1:0] t);
        wait_drained();
        wr_en    <= 1'b1;
        wr_index <= REG_BURST;
        wr_data  <= WDATA_W'(b);
        @(posedge clk);
        ledger.set_reg(REG_BURST, WDATA_W'(b));
        wr_index <= REG_SPACE;
        wr_data  <= WDATA_W'(s);
        @(posedge clk);
        ledger.set_reg(REG_SPACE, WDATA_W'(s));
        wr_index <= REG_TRAILER;
        wr_data  <= WDATA_W'(t);
        @(posedge clk);
        ledger.set_reg(REG_TRAILER, WDATA_W'(t));
        wr_en <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'(63);
            3:       return SAMPLE_W'(64);
            default: return SAMPLE_W'($urandom_range(1023));
        endcase
    endfunction

    task automatic finish_frame();
        while (ledger.sending)
            send_beat(OP_TICK, pick_sample());
    endtask

    // mostly ticks so frames run to the end; loads land both idle and mid-frame
    task automatic run_mix(input int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 6)
                send_beat(OP_LOAD, pick_sample());
            else
                send_beat(OP_TICK, pick_sample());
        end
    endtask

    initial
    begin
        cmd.valid  <= 1'b0;
        cmd.op     <= OP_TICK;
        cmd.sample <= '0;
        wr_en      <= 1'b0;
        wr_index   <= REG_BURST;
        wr_data    <= '0;
        calm        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle tick, load, load while busy, then shrink a running burst
        send_beat(OP_TICK, '1);
        send_beat(OP_LOAD, '1);
        send_beat(OP_LOAD, '0);
        repeat (6) send_beat(OP_TICK, '0);
        load_regs(8'd0, 8'd0, 10'd0);
        finish_frame();
        send_beat(OP_TICK, '0);
        send_beat(OP_LOAD, SAMPLE_W'(640));

        run_mix(30);
        for (int ph = 0; ph < 5; ph++)
        begin
            load_regs(BURST_W'($urandom_range(1, 4)), SPACE_W'($urandom_range(0, 4)),
                      TRAILER_W'($urandom_range(0, 12)));
            calm = (ph == 2);
            run_mix(calm ? 100 : 30);
            calm = 1'b0;
        end

        // largest settings: start a frame, cut short by the next write
        finish_frame();
        load_regs(8'd255, 8'd255, 10'd1023);
        send_beat(OP_LOAD, pick_sample());
        repeat (40) send_beat(OP_TICK, '0);

        // reset settings, cut short mid-frame by the next write
        load_regs(BURST_RESET, SPACE_RESET, TRAILER_RESET);
        run_mix(60);
        load_regs(8'd1, 8'd255, 10'd1);
        run_mix(30);
        load_regs(8'd1, 8'd1, 10'd1);
        run_mix(30);
        wait_drained();

        $display("tb: %0d command beats, %0d results checked, %0d frames completed",
                 ledger.n_cmds, ledger.n_checked, ledger.n_frames);
        $display("tb: %0d loads dropped mid-frame; segment lengths from 0 to 255/255/1023",
                 ledger.n_ignored);
        if (ledger.fails == 0 && ledger.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: ir_pulse_distance_transmitter.f
hw/rtl/ipdt_pkg.sv
hw/rtl/ipdt_if.sv
hw/rtl/ipdt_core.sv
hw/rtl/ir_pulse_distance_transmitter.sv
tb/tb_top.sv
